// ===== sv/sine_period_correlator_bank_assert.svh =====
// Assertion macros shared by the correlator bank RTL.
`ifndef SINE_PERIOD_CORRELATOR_BANK_ASSERT_SVH
`define SINE_PERIOD_CORRELATOR_BANK_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SPCB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define SPCB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/spcb_pkg.sv =====
// Shared types and constants of the sine period correlator bank.
`default_nettype none

package spcb_pkg;

   localparam int NUM_PERIODS_DEF  = 100;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int ACC_WIDTH_DEF    = 48;

   localparam int INDEX_W = 7;
   localparam int SINE_W  = 16;

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_READ   = 2'd1,
      REQ_CLEAR  = 2'd2
   } req_kind_type;

   typedef struct packed {
      logic                valid;
      req_kind_type        kind;
      logic [INDEX_W-1:0]  index;
      logic                sat;
   } spcb_ctl_type;

endpackage

`default_nettype wire

// ===== sv/spcb_cell.sv =====
// One period cell: sine lookup and multiply stage, then saturating accumulate stage.
`default_nettype none
`include "sine_period_correlator_bank_assert.svh"

module spcb_cell
   import spcb_pkg::*;
#(
   parameter int PERIOD       = 1,
   parameter int NUM_PERIODS  = NUM_PERIODS_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int ACC_WIDTH    = ACC_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  spcb_ctl_type                   up_ctl,
   input  logic signed [SAMPLE_WIDTH-1:0] up_sample,
   input  logic signed [ACC_WIDTH-1:0]    up_sum,
   output spcb_ctl_type                   dn_ctl,
   output logic signed [SAMPLE_WIDTH-1:0] dn_sample,
   output logic signed [ACC_WIDTH-1:0]    dn_sum
);

   localparam int PH_W         = $clog2(NUM_PERIODS);
   localparam int ROM_DEPTH    = 2 ** PH_W;
   localparam int PROD_W       = SAMPLE_WIDTH + SINE_W;
   localparam int SUM_W        = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;
   localparam int HORNER_TERMS = 7;
   localparam int SINE_FRAC    = SINE_W - 1;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] SINE_MAX    = (64'd1 << SINE_FRAC) - 64'd1;
   localparam logic [63:0] SIN_DENS [HORNER_TERMS] =
      '{64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
   localparam logic [63:0] COS_DENS [HORNER_TERMS] =
      '{64'd182, 64'd132, 64'd90, 64'd56, 64'd30, 64'd12, 64'd2};

   localparam logic [PH_W-1:0] PHASE_LAST = PH_W'(PERIOD - 1);
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = ~ACC_MIN;

   // Taylor series in Q2.30, truncating at each step.
   function automatic logic [63:0] horner(input logic [63:0] x2, input logic use_cos);
      logic [63:0] t;
      logic [63:0] d;
      t = Q30_ONE;
      for (int i = 0; i < HORNER_TERMS; i++) begin
         if (use_cos) begin
            d = ((x2 * t) >> 30) / COS_DENS[i];
         end else begin
            d = ((x2 * t) >> 30) / SIN_DENS[i];
         end
         t = (d > Q30_ONE) ? 64'd0 : Q30_ONE - d;
      end
      return t;
   endfunction

   function automatic logic signed [SINE_W-1:0] sine_entry(input int k);
      logic [63:0]       n;
      logic [63:0]       q;
      logic [63:0]       r;
      logic [63:0]       x;
      logic [63:0]       x2;
      logic [63:0]       v;
      logic [SINE_W-1:0] mag;
      n = 64'(4 * k);
      q = (n / PERIOD) & 64'd3;
      r = n % PERIOD;
      x = (r * HALF_PI_Q30) / PERIOD;
      x2 = (x * x) >> 30;
      if (q[0]) begin
         v = horner(x2, 1'b1);
      end else begin
         v = (x * horner(x2, 1'b0)) >> 30;
      end
      v = (v + (64'd1 << (SINE_FRAC - 1))) >> SINE_FRAC;
      if (v > SINE_MAX) begin
         v = SINE_MAX;
      end
      mag = SINE_W'(v);
      return q[1] ? $signed(-mag) : $signed(mag);
   endfunction

   logic signed [SINE_W-1:0] sine_rom [ROM_DEPTH];

   for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
      if (k < PERIOD) begin : g_used
         localparam logic signed [SINE_W-1:0] ENTRY = sine_entry(k);
         assign sine_rom[k] = ENTRY;
      end else begin : g_pad
         assign sine_rom[k] = '0;
      end
   end

   logic [PH_W-1:0]                phase_ff, phase_in;
   spcb_ctl_type                   a_ctl_ff, a_ctl_in;
   logic signed [SAMPLE_WIDTH-1:0] a_sample_ff, a_sample_in;
   logic signed [ACC_WIDTH-1:0]    a_sum_ff, a_sum_in;
   logic signed [PROD_W-1:0]       a_prod_ff, a_prod_in;
   spcb_ctl_type                   b_ctl_ff, b_ctl_in;
   logic signed [SAMPLE_WIDTH-1:0] b_sample_ff, b_sample_in;
   logic signed [ACC_WIDTH-1:0]    b_sum_ff, b_sum_in;
   logic signed [ACC_WIDTH-1:0]    acc_ff, acc_in;
   logic                           sat_ff, sat_in;

   logic signed [SUM_W-1:0]        sum_wide;
   logic                           overflow;
   logic                           match;

   assign sum_wide = SUM_W'(acc_ff) + SUM_W'(a_prod_ff);
   assign overflow = !((&sum_wide[SUM_W-1:ACC_WIDTH-1]) || !(|sum_wide[SUM_W-1:ACC_WIDTH-1]));
   assign match    = (int'(a_ctl_ff.index) == PERIOD);

   always_comb begin
      phase_in    = phase_ff;
      a_ctl_in    = a_ctl_ff;
      a_sample_in = a_sample_ff;
      a_sum_in    = a_sum_ff;
      a_prod_in   = a_prod_ff;
      b_ctl_in    = b_ctl_ff;
      b_sample_in = b_sample_ff;
      b_sum_in    = b_sum_ff;
      acc_in      = acc_ff;
      sat_in      = sat_ff;
      if (advance) begin
         a_ctl_in    = up_ctl;
         a_sample_in = up_sample;
         a_sum_in    = up_sum;
         a_prod_in   = PROD_W'(up_sample) * PROD_W'(sine_rom[phase_ff]);
         if (up_ctl.valid) begin
            unique case (up_ctl.kind)
               REQ_SAMPLE: phase_in = (phase_ff == PHASE_LAST) ? '0 : phase_ff + 1'b1;
               REQ_CLEAR:  phase_in = '0;
               default:    ;
            endcase
         end
         b_ctl_in    = a_ctl_ff;
         b_sample_in = a_sample_ff;
         b_sum_in    = a_sum_ff;
         if (a_ctl_ff.valid) begin
            unique case (a_ctl_ff.kind)
               REQ_SAMPLE: begin
                  if (overflow) begin
                     acc_in = sum_wide[SUM_W-1] ? ACC_MIN : ACC_MAX;
                     sat_in = 1'b1;
                  end else begin
                     acc_in = sum_wide[ACC_WIDTH-1:0];
                  end
               end
               REQ_READ: begin
                  if (match) begin
                     b_sum_in     = acc_ff;
                     b_ctl_in.sat = sat_ff;
                  end
               end
               REQ_CLEAR: begin
                  acc_in = '0;
                  sat_in = 1'b0;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
         acc_ff   <= '0;
         sat_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         a_ctl_ff <= a_ctl_in;
         b_ctl_ff <= b_ctl_in;
         acc_ff   <= acc_in;
         sat_ff   <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sample_ff <= a_sample_in;
      a_sum_ff    <= a_sum_in;
      a_prod_ff   <= a_prod_in;
      b_sample_ff <= b_sample_in;
      b_sum_ff    <= b_sum_in;
   end

   assign dn_ctl    = b_ctl_ff;
   assign dn_sample = b_sample_ff;
   assign dn_sum    = b_sum_ff;

   `SPCB_ASSERT_NOW(a_phase_range, 1'b1, int'(phase_ff) < PERIOD, "phase beyond period")
   `SPCB_ASSERT_NEXT(a_clear_zeroes, advance && a_ctl_ff.valid && a_ctl_ff.kind == REQ_CLEAR, acc_ff == '0 && !sat_ff, "clear left state")
   `SPCB_ASSERT_NEXT(a_stall_holds, !advance, $stable(acc_ff) && $stable(phase_ff), "state moved in stall")

endmodule

`default_nettype wire

// ===== sv/sine_period_correlator_bank.sv =====
// A read passes every cell's stage registers, then the response register.
// Throughput: one transaction per cycle unless the response stalls; each
// cell registers sine lookup and multiply, then the saturating accumulate.
// A stalled response freezes the whole cell chain.
// Reset clears all accumulators, phase counters and saturation flags at once.
// Top level: chain of per-period cells plus the response register.
`default_nettype none
`include "sine_period_correlator_bank_assert.svh"

module sine_period_correlator_bank
   import spcb_pkg::*;
#(
   parameter int NUM_PERIODS  = NUM_PERIODS_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int ACC_WIDTH    = ACC_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_type,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic [INDEX_W-1:0]             req_period_index,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [ACC_WIDTH-1:0]    rsp_period_sum,
   output logic [INDEX_W-1:0]             rsp_period_echo,
   output logic                           rsp_saturated
);

   spcb_ctl_type                   chain_ctl    [NUM_PERIODS];
   logic signed [SAMPLE_WIDTH-1:0] chain_sample [NUM_PERIODS];
   logic signed [ACC_WIDTH-1:0]    chain_sum    [NUM_PERIODS];

   logic                           advance;
   logic                           tail_read;
   spcb_ctl_type                   tail;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_WIDTH-1:0]    rsp_sum_ff, rsp_sum_in;
   logic [INDEX_W-1:0]             rsp_echo_ff, rsp_echo_in;
   logic                           rsp_sat_ff, rsp_sat_in;

   assign advance = !rsp_valid_ff || rsp_ready;

   always_comb begin
      chain_ctl[0].valid = req_valid;
      chain_ctl[0].kind  = req_kind_type'(req_type);
      chain_ctl[0].index = req_period_index;
      chain_ctl[0].sat   = 1'b0;
   end
   assign chain_sample[0] = req_sample;
   assign chain_sum[0]    = '0;

   for (genvar p = 1; p < NUM_PERIODS; p++) begin : g_cell
      spcb_cell #(
         .PERIOD       (p),
         .NUM_PERIODS  (NUM_PERIODS),
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .ACC_WIDTH    (ACC_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .up_ctl    (chain_ctl[p-1]),
         .up_sample (chain_sample[p-1]),
         .up_sum    (chain_sum[p-1]),
         .dn_ctl    (chain_ctl[p]),
         .dn_sample (chain_sample[p]),
         .dn_sum    (chain_sum[p])
      );
   end

   assign tail      = chain_ctl[NUM_PERIODS-1];
   assign tail_read = tail.valid && (tail.kind == REQ_READ);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_echo_in  = rsp_echo_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (advance) begin
         rsp_valid_in = tail_read;
         if (tail_read) begin
            rsp_sum_in  = chain_sum[NUM_PERIODS-1];
            rsp_echo_in = tail.index;
            rsp_sat_in  = tail.sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sum_ff  <= rsp_sum_in;
      rsp_echo_ff <= rsp_echo_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign req_ready       = advance;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_period_sum  = rsp_sum_ff;
   assign rsp_period_echo = rsp_echo_ff;
   assign rsp_saturated   = rsp_sat_ff;

   `SPCB_ASSERT_NOW(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready, "request taken in stall")
   `SPCB_ASSERT_NEXT(a_read_emits, advance && tail_read, rsp_valid, "read lost at chain tail")
   `SPCB_ASSERT_NEXT(a_other_silent, advance && !tail_read, !rsp_valid, "response without read")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench of sine_period_correlator_bank with its own correlator model.
`default_nettype none

module tb;
   import spcb_pkg::*;

   localparam int NUM_P = NUM_PERIODS_DEF;
   localparam int SMP_W = SAMPLE_WIDTH_DEF;
   localparam int ACC_W = ACC_WIDTH_DEF;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam longint unsigned Q30_ONE     = 64'd1 << 30;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint          ACC_HI      = (64'sd1 <<< (ACC_W - 1)) - 1;
   localparam longint          ACC_LO      = -ACC_HI - 1;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 2 * (NUM_P - 1) + 50;
   localparam int HOLD_CYCLES    = 600;
   localparam int DRIVE_COUNT    = 60;

   typedef struct packed {
      logic signed [ACC_W-1:0] sum;
      logic [INDEX_W-1:0]      echo;
      logic                    sat;
   } period_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_type = REQ_SAMPLE;
   logic signed [SMP_W-1:0] req_sample = '0;
   logic [INDEX_W-1:0]      req_period_index = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [ACC_W-1:0] rsp_period_sum;
   logic [INDEX_W-1:0]      rsp_period_echo;
   logic                    rsp_saturated;

   sine_period_correlator_bank u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_sample       (req_sample),
      .req_period_index (req_period_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_period_sum   (rsp_period_sum),
      .rsp_period_echo  (rsp_period_echo),
      .rsp_saturated    (rsp_saturated)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   shortint           sine_lut [NUM_P][NUM_P];
   longint            acc_model [NUM_P];
   int                phase_model [NUM_P];
   bit                sat_model [NUM_P];
   period_result_type expected_results [$];

   int err_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_cycles = 0;
   int hold_left = 0;
   int hold_len = 0;
   bit hold_trig = 1'b0;
   bit hold_seen = 1'b0;

   function automatic longint unsigned taylor_q30(input longint unsigned x2,
                                                  input bit cos_series);
      longint unsigned term, d, den;
      term = Q30_ONE;
      for (int i = 0; i < 7; i++) begin
         case (i)
            0: den = cos_series ? 182 : 210;
            1: den = cos_series ? 132 : 156;
            2: den = cos_series ? 90 : 110;
            3: den = cos_series ? 56 : 72;
            4: den = cos_series ? 30 : 42;
            5: den = cos_series ? 12 : 20;
            default: den = cos_series ? 2 : 6;
         endcase
         d = ((x2 * term) >> 30) / den;
         term = (d > Q30_ONE) ? 64'd0 : Q30_ONE - d;
      end
      return term;
   endfunction

   function automatic shortint sine_q15(input int unsigned p, input int unsigned k);
      longint unsigned n, q, r, x, x2, v;
      int s;
      n  = 4 * k;
      q  = (n / p) & 3;
      r  = n % p;
      x  = (r * HALF_PI_Q30) / p;
      x2 = (x * x) >> 30;
      if (q[0])
         v = taylor_q30(x2, 1'b1);
      else
         v = (x * taylor_q30(x2, 1'b0)) >> 30;
      v = (v + (64'd1 << 14)) >> 15;
      if (v > 32767)
         v = 32767;
      s = int'(v);
      if (q >= 2)
         s = -s;
      return shortint'(s);
   endfunction

   task automatic clear_model();
      for (int p = 0; p < NUM_P; p++) begin
         acc_model[p]   = 0;
         phase_model[p] = 0;
         sat_model[p]   = 1'b0;
      end
   endtask

   task automatic apply_to_model(input logic [1:0] kind, input logic [SMP_W-1:0] smp_bits,
                                 input logic [INDEX_W-1:0] idx);
      longint            smp, prod, acc;
      int                ph;
      period_result_type res;
      case (kind)
         REQ_SAMPLE: begin
            smp = $signed(smp_bits);
            for (int p = 1; p < NUM_P; p++) begin
               ph = phase_model[p];
               if (ph >= p)
                  ph = 0;
               prod = smp * longint'(sine_lut[p][ph]);
               acc  = acc_model[p];
               if (prod > 0 && acc > ACC_HI - prod) begin
                  acc = ACC_HI;
                  sat_model[p] = 1'b1;
               end else if (prod < 0 && acc < ACC_LO - prod) begin
                  acc = ACC_LO;
                  sat_model[p] = 1'b1;
               end else begin
                  acc = acc + prod;
               end
               acc_model[p]   = acc;
               phase_model[p] = (ph + 1 == p) ? 0 : ph + 1;
            end
         end
         REQ_READ: begin
            res.echo = idx;
            res.sum  = '0;
            res.sat  = 1'b0;
            if (idx >= 1 && idx < NUM_P) begin
               res.sum = acc_model[idx][ACC_W-1:0];
               res.sat = sat_model[idx];
            end
            expected_results.push_back(res);
         end
         REQ_CLEAR: clear_model();
         default: ;
      endcase
   endtask

   // One transaction on the request channel; returns at the accepting edge.
   task automatic send_req(input logic [1:0] kind, input logic [SMP_W-1:0] smp_bits,
                           input logic [INDEX_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_sample       <= smp_bits;
      req_period_index <= idx;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      apply_to_model(kind, smp_bits, idx);
   endtask

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      err_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else if (hold_trig != hold_seen) begin
         hold_seen <= hold_trig;
         hold_left <= hold_len;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      period_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result for period %0d", rsp_period_echo));
         end else begin
            want = expected_results.pop_front();
            if (rsp_period_echo !== want.echo)
               report_mismatch($sformatf("period_echo got %0d want %0d",
                                         rsp_period_echo, want.echo));
            if (rsp_period_sum !== want.sum)
               report_mismatch($sformatf("period %0d sum got %0d want %0d",
                                         want.echo, rsp_period_sum, want.sum));
            if (rsp_saturated !== want.sat)
               report_mismatch($sformatf("period %0d saturated got %0b want %0b",
                                         want.echo, rsp_saturated, want.sat));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic test_reads_after_reset();
      send_req(REQ_READ, '0, 7'd0);
      send_req(REQ_READ, '0, 7'd1);
      send_req(REQ_READ, '0, 7'd99);
      send_req(REQ_READ, '0, 7'd100);
      send_req(REQ_READ, '0, 7'd127);
   endtask

   task automatic test_sample_extremes();
      send_req(REQ_SAMPLE, 16'h7FFF, 7'd0);
      send_req(REQ_SAMPLE, 16'h8000, 7'd127);
      send_req(REQ_SAMPLE, 16'h0000, 7'd0);
      send_req(REQ_SAMPLE, 16'hFFFF, 7'd127);
      send_req(REQ_SAMPLE, 16'h0001, 7'd0);
      send_req(REQ_SAMPLE, 16'h5555, 7'd85);
      send_req(REQ_SAMPLE, 16'hAAAA, 7'd42);
      send_req(REQ_READ, 16'hFFFF, 7'd1);
      send_req(REQ_READ, '0, 7'd3);
      send_req(REQ_READ, '0, 7'd4);
      send_req(REQ_READ, '0, 7'd7);
      send_req(REQ_READ, '0, 7'd50);
      send_req(REQ_READ, '0, 7'd99);
      send_req(REQ_UNUSED, 16'hFFFF, 7'd127);
      send_req(REQ_READ, '0, 7'd4);
      send_req(REQ_CLEAR, 16'hFFFF, 7'd127);
      send_req(REQ_READ, '0, 7'd4);
      send_req(REQ_READ, '0, 7'd99);
   endtask

   // Drive full-scale samples in phase (or anti-phase) with one period's sine.
   task automatic drive_in_phase(input int p, input bit negative);
      shortint s;
      logic [SMP_W-1:0] smp;
      for (int i = 0; i < DRIVE_COUNT; i++) begin
         s = sine_lut[p][phase_model[p]];
         if (s == 0)
            smp = '0;
         else if ((s > 0) != negative)
            smp = 16'h7FFF;
         else
            smp = 16'h8000;
         send_req(REQ_SAMPLE, smp, '0);
      end
      for (int i = 0; i < 20; i++)
         send_req(REQ_SAMPLE, negative ? 16'h8000 : 16'h7FFF, '0);
      send_req(REQ_READ, '0, p[INDEX_W-1:0]);
      send_req(REQ_READ, '0, 7'd4);
      send_req(REQ_READ, '0, 7'd98);
      send_req(REQ_CLEAR, '0, '0);
      send_req(REQ_READ, '0, p[INDEX_W-1:0]);
   endtask

   task automatic test_full_scale();
      drive_in_phase(64, 1'b0);
      drive_in_phase(97, 1'b1);
   endtask

   task automatic test_back_pressure();
      hold_len  <= HOLD_CYCLES;
      hold_trig <= ~hold_trig;
      for (int i = 0; i < 300; i++) begin
         if (i % 3 == 0)
            send_req(REQ_SAMPLE, 16'($urandom_range(0, 65535)), '0);
         else
            send_req(REQ_READ, '0, 7'($urandom_range(1, NUM_P - 1)));
      end
   endtask

   task automatic run_random_phase(input int items);
      int count, pick;
      logic [SMP_W-1:0] smp;
      count = 0;
      while (count < items) begin
         pick = $urandom_range(99);
         if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
               0: smp = 16'h7FFF;
               1: smp = 16'h8000;
               2: smp = 16'hFFFF;
               default: smp = 16'h0000;
            endcase
         end else begin
            smp = 16'($urandom_range(0, 65535));
         end
         if (pick < 68) begin
            send_req(REQ_SAMPLE, smp, 7'($urandom_range(0, 127)));
            count++;
         end else if (pick < 90) begin
            send_req(REQ_READ, smp, 7'($urandom_range(0, 127)));
            count++;
         end else if (pick < 95) begin
            send_req(REQ_CLEAR, smp, 7'($urandom_range(0, 127)));
            count++;
         end else begin
            send_req(REQ_UNUSED, smp, 7'($urandom_range(0, 127)));
         end
      end
   endtask

   task automatic test_random_traffic();
      send_idle_pct = 35;
      recv_idle_pct = 69;
      run_random_phase(250);
      send_idle_pct = 69;
      recv_idle_pct = 35;
      run_random_phase(250);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phase(250);
   endtask

   initial begin
      for (int p = 1; p < NUM_P; p++)
         for (int k = 0; k < p; k++)
            sine_lut[p][k] = sine_q15(p, k);
      clear_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 35;
      recv_idle_pct = 69;
      test_reads_after_reset();
      test_sample_extremes();
      test_full_scale();
      test_back_pressure();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/spcb_pkg.sv
sv/spcb_cell.sv
sv/sine_period_correlator_bank.sv
tb/sv/tb.sv
